FILE: src/wpma_pkg.sv
// Package for the wrapped pot moving average core.
// Holds configuration and result types, register indexes and queue sizes.
// No dependencies.
`timescale 1ns / 1ps

package wpma_pkg;

    localparam int ANGLE_W   = 16;
    localparam int LIMIT_W   = 15;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT   = 8'd3;

    localparam logic signed [ANGLE_W-1:0] RANGE_LOW_RST  = 16'sd0;
    localparam logic signed [ANGLE_W-1:0] RANGE_HIGH_RST = 16'sd5760;
    localparam logic signed [ANGLE_W-1:0] OFFSET_RST     = 16'sd0;
    localparam logic [LIMIT_W-1:0]        JUMP_LIMIT_RST = 15'd4800;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic signed [ANGLE_W-1:0] range_low;
        logic signed [ANGLE_W-1:0] range_high;
        logic signed [ANGLE_W-1:0] angle_offset;
        logic [LIMIT_W-1:0]        jump_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] smoothed_angle;
        logic signed [ANGLE_W-1:0] window_mean;
        logic                      window_full;
    } out_item_t;

endpackage

FILE: src/wpma_fifo.sv
// Small register queue used between the front and back and at the output.
// Depends on nothing; width and depth come from parameters.
`timescale 1ns / 1ps

module wpma_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign do_wr   = wr_en && (count_reg != CW'(DEPTH));
    assign do_rd   = rd_en && (count_reg != '0);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign count   = count_reg;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: src/wpma_front.sv
// Front end: accepts readings, rejects large rises, applies offset and wrap.
// Depends on wpma_pkg; feeds the middle queue.
`timescale 1ns / 1ps

module wpma_front
    import wpma_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      push,
    input  logic signed [ANGLE_W-1:0] raw_angle,
    output logic                      full,
    input  logic                      q_full,
    output logic                      q_wr,
    output logic signed [ANGLE_W-1:0] q_data
);

    logic                      s_valid_reg, s_valid_next;
    logic signed [ANGLE_W-1:0] reading_reg, reading_next;
    logic signed [ANGLE_W-1:0] prev_reg, prev_next;
    logic                      accept;
    logic signed [ANGLE_W:0]   rise;
    logic signed [ANGLE_W+1:0] v, span;
    logic signed [ANGLE_W+2:0] v_minus, v_plus, wrapped;

    assign accept = push && !full;
    assign full   = s_valid_reg && q_full;
    assign q_wr   = s_valid_reg && !q_full;

    always_comb
    begin
        rise         = (ANGLE_W+1)'(raw_angle) - (ANGLE_W+1)'(prev_reg);
        reading_next = reading_reg;
        prev_next    = prev_reg;
        if (accept)
        begin
            if ($signed({rise[ANGLE_W], rise}) > $signed({3'b000, cfg.jump_limit}))
            begin
                reading_next = prev_reg;
            end
            else
            begin
                reading_next = raw_angle;
            end
            prev_next = reading_next;
        end
        s_valid_next = accept ? 1'b1 : (q_wr ? 1'b0 : s_valid_reg);
    end

    always_comb
    begin
        v       = (ANGLE_W+2)'(reading_reg) + (ANGLE_W+2)'(cfg.angle_offset);
        span    = (ANGLE_W+2)'(cfg.range_high) - (ANGLE_W+2)'(cfg.range_low);
        v_minus = (ANGLE_W+3)'(v) - (ANGLE_W+3)'(span);
        v_plus  = (ANGLE_W+3)'(v) + (ANGLE_W+3)'(span);
        if (v > (ANGLE_W+2)'(cfg.range_high))
        begin
            wrapped = (v_minus < (ANGLE_W+3)'(cfg.range_low)) ? (ANGLE_W+3)'(v) : v_minus;
        end
        else
        begin
            wrapped = (v < (ANGLE_W+2)'(cfg.range_low)) ? v_plus : (ANGLE_W+3)'(v);
        end
        if (wrapped > (ANGLE_W+3)'(16'sh7fff))
        begin
            q_data = 16'sh7fff;
        end
        else if (wrapped < (ANGLE_W+3)'(-19'sd32768))
        begin
            q_data = -16'sd32768;
        end
        else
        begin
            q_data = wrapped[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            prev_reg    <= '0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            prev_reg    <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reading_reg <= reading_next;
    end

endmodule

FILE: src/wpma_back.sv
// Back end: shifts wrapped samples into the window, keeps the running sum
// and forms the floor mean by reciprocal multiply. Depends on wpma_pkg.
`timescale 1ns / 1ps

module wpma_back
    import wpma_pkg::*;
#(
    parameter int WINDOW_LEN = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  logic signed [ANGLE_W-1:0] q_data,
    output logic                      q_rd,
    input  logic [OUT_CNT_W-1:0]      out_count,
    output logic                      out_wr,
    output out_item_t                 out_data
);

    localparam int LW   = $clog2(WINDOW_LEN);
    localparam int UW   = ANGLE_W + LW;
    localparam int MW   = UW + 2;
    localparam int PW   = UW + MW;
    localparam int K    = UW + LW;
    localparam int FW   = $clog2(WINDOW_LEN + 1);
    localparam logic [UW-1:0] BIAS  = UW'(32768 * WINDOW_LEN);
    localparam logic [MW-1:0] MUL_M = MW'(((64'd1 << K) + 64'(WINDOW_LEN) - 64'd1)
                                          / 64'(WINDOW_LEN));

    logic signed [ANGLE_W-1:0] win_reg [WINDOW_LEN];
    logic [UW-1:0]             ubias_reg, ubias_next;
    logic [FW-1:0]             fill_reg, fill_next;
    logic                      s1_valid_reg, s2_valid_reg;
    logic signed [ANGLE_W-1:0] s1_wrapped_reg, s2_wrapped_reg;
    logic                      s1_full_reg, s2_full_reg;
    logic [PW-1:0]             prod_reg;
    logic [OUT_CNT_W+1:0]      pending;
    logic [ANGLE_W-1:0]        mean_raw;
    logic signed [ANGLE_W-1:0] mean;
    logic signed [UW+1:0]      sum_wide;

    assign pending = (OUT_CNT_W+2)'(out_count) + (OUT_CNT_W+2)'(s1_valid_reg)
                   + (OUT_CNT_W+2)'(s2_valid_reg);
    assign q_rd    = !q_empty && (pending < (OUT_CNT_W+2)'(OUT_DEPTH));

    always_comb
    begin
        sum_wide   = $signed({2'b00, ubias_reg}) + (UW+2)'(q_data) - (UW+2)'(win_reg[0]);
        ubias_next = sum_wide[UW-1:0];
        fill_next  = (fill_reg < FW'(WINDOW_LEN)) ? fill_reg + 1'b1 : fill_reg;
    end

    assign mean_raw = prod_reg[K +: ANGLE_W];
    assign mean     = {~mean_raw[ANGLE_W-1], mean_raw[ANGLE_W-2:0]};

    always_comb
    begin
        out_wr                  = s2_valid_reg;
        out_data.window_mean    = mean;
        out_data.window_full    = s2_full_reg;
        out_data.smoothed_angle = s2_full_reg ? mean : s2_wrapped_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
            ubias_reg    <= BIAS;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_rd)
            begin
                for (int i = 0; i < WINDOW_LEN - 1; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WINDOW_LEN-1] <= q_data;
                ubias_reg <= ubias_next;
                fill_reg  <= fill_next;
            end
            s1_valid_reg <= q_rd;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_wrapped_reg <= q_data;
        s1_full_reg    <= (fill_reg >= FW'(WINDOW_LEN - 1));
        s2_wrapped_reg <= s1_wrapped_reg;
        s2_full_reg    <= s1_full_reg;
        prod_reg       <= PW'(ubias_reg) * PW'(MUL_M);
    end

endmodule

FILE: src/wrapped_pot_moving_average_core.sv
// Wrapped potentiometer angle smoother: one Q12.4 reading in, one result out
// per reading. One reading per clock unless results back up; the running sum
// updates with each window shift. A result goes via the front reading
// register, the middle queue and back end s1 and s2 registers to the output
// queue. Config is taken on any cycle, cfg_ready stays high. No clearing pass.
`timescale 1ns / 1ps

module wrapped_pot_moving_average_core
    import wpma_pkg::*;
#(
    parameter int WINDOW_LEN = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [ANGLE_W-1:0] raw_angle,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [ANGLE_W-1:0] smoothed_angle,
    output logic signed [ANGLE_W-1:0] window_mean,
    output logic                      window_full,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [ANGLE_W-1:0]        cfg_data
);

    cfg_t                      cfg_reg, cfg_next;
    logic                      mid_full, mid_empty, mid_wr, mid_rd;
    logic signed [ANGLE_W-1:0] mid_wr_data, mid_rd_data;
    logic                      out_wr;
    out_item_t                 out_wr_data, out_rd_data;
    logic [OUT_CNT_W-1:0]      out_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RANGE_LOW:    cfg_next.range_low    = cfg_data;
                REG_RANGE_HIGH:   cfg_next.range_high   = cfg_data;
                REG_ANGLE_OFFSET: cfg_next.angle_offset = cfg_data;
                REG_JUMP_LIMIT:   cfg_next.jump_limit   = cfg_data[LIMIT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_low    <= RANGE_LOW_RST;
            cfg_reg.range_high   <= RANGE_HIGH_RST;
            cfg_reg.angle_offset <= OFFSET_RST;
            cfg_reg.jump_limit   <= JUMP_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wpma_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .raw_angle (raw_angle),
        .full      (full),
        .q_full    (mid_full),
        .q_wr      (mid_wr),
        .q_data    (mid_wr_data)
    );

    wpma_fifo #(
        .WIDTH (ANGLE_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr),
        .wr_data (mid_wr_data),
        .rd_en   (mid_rd),
        .rd_data (mid_rd_data),
        .empty   (mid_empty),
        .full    (mid_full),
        .count   ()
    );

    wpma_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (mid_empty),
        .q_data    (mid_rd_data),
        .q_rd      (mid_rd),
        .out_count (out_count),
        .out_wr    (out_wr),
        .out_data  (out_wr_data)
    );

    wpma_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr),
        .wr_data (out_wr_data),
        .rd_en   (pop),
        .rd_data (out_rd_data),
        .empty   (empty),
        .full    (),
        .count   (out_count)
    );

    assign smoothed_angle = out_rd_data.smoothed_angle;
    assign window_mean    = out_rd_data.window_mean;
    assign window_full    = out_rd_data.window_full;

endmodule

FILE: src/wpma_checker.sv
// Port-level checks for the wrapped pot moving average core.
// Depends on wpma_pkg; bound to the top level below.
`timescale 1ns / 1ps

module wpma_checker
    import wpma_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      empty,
    input logic                      pop,
    input logic signed [ANGLE_W-1:0] smoothed_angle,
    input logic signed [ANGLE_W-1:0] window_mean,
    input logic                      window_full
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(smoothed_angle)
                              && $stable(window_mean) && $stable(window_full)))
        else $error("stalled result request changed");

    a_full_mean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && window_full) |-> (smoothed_angle == window_mean))
        else $error("full window result is not the mean");

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && window_full) |=> (empty || window_full))
        else $error("window full dropped after being set");

endmodule

bind wrapped_pot_moving_average_core wpma_checker u_wpma_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .smoothed_angle (smoothed_angle),
    .window_mean    (window_mean),
    .window_full    (window_full)
);
